[src/lms_pkg.sv]
`default_nettype none

package lms_pkg;

  localparam int COLUMNS_DEF   = 32;
  localparam int HALF_ROWS_DEF = 8;
  localparam int MAX_OUT       = 32;
  localparam int COLOR_W       = 12;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SELECT = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  function automatic logic [2:0] lit_bits(input logic [COLOR_W-1:0] pix,
                                          input logic [3:0] thr);
    lit_bits = {pix[11:8] > thr, pix[7:4] > thr, pix[3:0] > thr};
  endfunction

endpackage

`default_nettype wire

[src/lms_if.sv]
`default_nettype none

interface lms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  column_x;
  logic [3:0]  row_y;
  logic [11:0] color;
  logic        buffer_choice;
  logic [2:0]  scan_line;
  logic [3:0]  threshold;
  logic        chain_in;

  modport source(output valid, kind, column_x, row_y, color, buffer_choice,
                 scan_line, threshold, chain_in, input ready);
  modport sink(input valid, kind, column_x, row_y, color, buffer_choice,
               scan_line, threshold, chain_in, output ready);
endinterface

interface lms_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_column;
  logic [2:0] row_address;
  logic [2:0] upper_rgb;
  logic [2:0] lower_rgb;
  logic       chain_out;
  logic       latch;

  modport source(output valid, out_column, row_address, upper_rgb, lower_rgb,
                 chain_out, latch, input ready);
  modport sink(input valid, out_column, row_address, upper_rgb, lower_rgb,
               chain_out, latch, output ready);
endinterface

`default_nettype wire

[src/lms_ram.sv]
`default_nettype none

module lms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/led_matrix_scanout.sv]
`default_nettype none

// Double-buffered RGB444 frame store and scan-out for a two-half scanned LED
// matrix. Pixel writes go to the back buffer, a select transaction picks the
// displayed buffer, and a scan transaction emits one result transaction per
// column (up to 32) with the lit bits of the upper and lower rows, the latch
// mark on the last column. Each half of the panel lives in its own RAM, so a
// scan reads both rows of a column in the same cycle. A scan holds off the
// input until the read data of its last column has moved to the result
// register, and longer while the result side stalls, while a write or a
// select does not hold off the input. After reset a clearing pass zeroes
// both RAMs, during which no input transaction is accepted.
module led_matrix_scanout #(
  parameter int COLUMNS   = lms_pkg::COLUMNS_DEF,
  parameter int HALF_ROWS = lms_pkg::HALF_ROWS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lms_in_if.sink    in_ch,
  lms_out_if.source out_ch
);

  localparam int BUF_WORDS = HALF_ROWS * COLUMNS;
  localparam int DEPTH     = 2 * BUF_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int NCOL      = (COLUMNS < lms_pkg::MAX_OUT) ? COLUMNS : lms_pkg::MAX_OUT;
  localparam int CW        = $clog2(NCOL);

  lms_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          disp_r, disp_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_col_r;
  logic          pend_last_r;
  logic [AW-1:0] rbase_r;
  logic [2:0]    row_r;
  logic [3:0]    thr_r;
  logic          chain_r;
  logic          out_valid_r, out_valid_nxt;

  logic accept, move, rd_en, last_col, clearing;
  logic is_write, is_select, is_scan;
  logic [AW-1:0] x_ext, y_ext, wrow, waddr, line_ext, srow, sbase;
  logic          in_range, lower;
  logic          wr_en_up, wr_en_lo;
  logic [AW-1:0] wr_addr;
  logic [lms_pkg::COLOR_W-1:0] wr_data, rd_up, rd_lo;
  logic [AW-1:0] rd_addr;

  assign clearing  = (state_r == lms_pkg::ST_CLEAR);
  assign in_ch.ready = (state_r == lms_pkg::ST_IDLE) && !pend_r;
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_write  = accept && (in_ch.kind == lms_pkg::KIND_WRITE);
  assign is_select = accept && (in_ch.kind == lms_pkg::KIND_SELECT);
  assign is_scan   = accept && (in_ch.kind == lms_pkg::KIND_SCAN);
  assign move      = pend_r && (!out_valid_r || out_ch.ready);
  assign rd_en     = (state_r == lms_pkg::ST_SCAN) && (!pend_r || move);
  assign last_col  = (col_r == CW'(NCOL - 1));

  always_comb begin
    x_ext    = AW'(in_ch.column_x);
    y_ext    = AW'(in_ch.row_y);
    in_range = (x_ext < AW'(COLUMNS)) && (y_ext < AW'(2 * HALF_ROWS));
    lower    = (y_ext >= AW'(HALF_ROWS));
    wrow     = lower ? (y_ext - AW'(HALF_ROWS)) : y_ext;
    waddr    = (disp_r ? '0 : AW'(BUF_WORDS)) + wrow * AW'(COLUMNS) + x_ext;
    line_ext = AW'(in_ch.scan_line);
    srow     = (line_ext >= AW'(HALF_ROWS)) ? (line_ext - AW'(HALF_ROWS)) : line_ext;
    sbase    = (disp_r ? AW'(BUF_WORDS) : '0) + srow * AW'(COLUMNS);
  end

  assign wr_en_up = clearing || (is_write && in_range && !lower);
  assign wr_en_lo = clearing || (is_write && in_range && lower);
  assign wr_addr  = clearing ? clr_r : waddr;
  assign wr_data  = clearing ? '0 : in_ch.color;
  assign rd_addr  = rbase_r + AW'(col_r);

  lms_ram #(.WIDTH(lms_pkg::COLOR_W), .DEPTH(DEPTH)) u_ram_upper (
    .clk     (clk),
    .wr_en   (wr_en_up),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_up)
  );

  lms_ram #(.WIDTH(lms_pkg::COLOR_W), .DEPTH(DEPTH)) u_ram_lower (
    .clk     (clk),
    .wr_en   (wr_en_lo),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_lo)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    disp_nxt      = disp_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      lms_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = lms_pkg::ST_IDLE;
        end
      end
      lms_pkg::ST_IDLE: begin
        if (is_scan) begin
          state_nxt = lms_pkg::ST_SCAN;
          col_nxt   = '0;
        end
        if (is_select) begin
          disp_nxt = in_ch.buffer_choice;
        end
      end
      lms_pkg::ST_SCAN: begin
        if (rd_en) begin
          col_nxt = col_r + CW'(1);
          if (last_col) begin
            state_nxt = lms_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lms_pkg::ST_CLEAR;
      end
    endcase
    if (rd_en) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lms_pkg::ST_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      disp_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      col_r       <= col_nxt;
      disp_r      <= disp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_scan) begin
      rbase_r <= sbase;
      row_r   <= 3'(srow);
      thr_r   <= in_ch.threshold;
      chain_r <= in_ch.chain_in;
    end
    if (rd_en) begin
      pend_col_r  <= col_r;
      pend_last_r <= last_col;
    end
    if (move) begin
      out_ch.out_column  <= 5'(pend_col_r);
      out_ch.row_address <= row_r;
      out_ch.upper_rgb   <= lms_pkg::lit_bits(rd_up, thr_r);
      out_ch.lower_rgb   <= lms_pkg::lit_bits(rd_lo, thr_r);
      out_ch.chain_out   <= chain_r;
      out_ch.latch       <= pend_last_r;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready)
    else $error("Input accepted during the clearing pass.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lms_pkg::ST_SCAN) |-> !(wr_en_up || wr_en_lo))
    else $error("Frame store written during a scan.");

  a_read_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> pend_r)
    else $error("Issued read did not mark pending data.");

  a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !move && !rd_en) |=> pend_r)
    else $error("Pending read data dropped before it moved to the output.");

  a_latch_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.latch) |-> (out_ch.out_column == 5'(NCOL - 1)))
    else $error("Latch marked on a column other than the last.");
`endif

endmodule

`default_nettype wire
